// File: design/utc_pkg.sv
// Shared types and constants for the UUID timestamp codec.
package utc_pkg;

    typedef enum logic [2:0] {
        MODE_ENC_V1 = 3'd0,
        MODE_ENC_V6 = 3'd1,
        MODE_ENC_V7 = 3'd2,
        MODE_DEC_V1 = 3'd3,
        MODE_DEC_V6 = 3'd4,
        MODE_DEC_V7 = 3'd5
    } mode_t;

    // 100 ns ticks from 1582-10-15 to the Unix epoch
    localparam logic [63:0] GREG_OFFSET = 64'h01b21dd213814000;
    // largest tick count whose product with 100 still fits 64 bits
    localparam logic [59:0] GREG_LIMIT  = 60'd184467440737095516;
    // largest millisecond count whose product with 1e6 still fits 64 bits
    localparam logic [47:0] MS_LIMIT    = 48'd18446744073709;
    // ceil(2^30 / 1000), exact for numerators below 2^22
    localparam logic [20:0] RECIP_1000  = 21'd1073742;

    localparam logic [3:0] VER_V1 = 4'h1;
    localparam logic [3:0] VER_V6 = 4'h6;
    localparam logic [3:0] VER_V7 = 4'h7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] time_ns;
        logic [63:0] field_bytes;
    } div_in_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] field_bytes;
        logic [57:0] q100;
        logic [47:0] q_ms;
        logic [19:0] r_ms;
    } div_out_t;

endpackage

// File: design/utc_if.sv
// Stream interfaces for the codec input and result channels.
interface utc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] time_ns;
    logic [63:0] field_bytes;

    modport source (output valid, output mode, output time_ns, output field_bytes,
                    input ready);
    modport sink   (input valid, input mode, input time_ns, input field_bytes,
                    output ready);
endinterface

interface utc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_bytes;
    logic [63:0] decoded_ns;
    logic        out_of_range;

    modport source (output valid, output packed_bytes, output decoded_ns,
                    output out_of_range, input ready);
    modport sink   (input valid, input packed_bytes, input decoded_ns,
                    input out_of_range, output ready);
endinterface

// File: design/utc_div_pipe.sv
// Eight-stage restoring divider: time_ns / 100 and time_ns / 1e6, one byte per stage.
module utc_div_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  utc_pkg::div_in_t   up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output utc_pkg::div_out_t  dn_data
);
    import utc_pkg::*;

    localparam int NSTAGE = 8;
    localparam logic [7:0]  D100 = 8'd100;
    localparam logic [20:0] D1M  = 21'd1000000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] time_ns;
        logic [63:0] field_bytes;
        logic [6:0]  r100;
        logic [57:0] q100;
        logic [19:0] r_ms;
        logic [47:0] q_ms;
    } stage_t;

    stage_t st_reg [NSTAGE];
    stage_t st_next [NSTAGE];
    stage_t src [NSTAGE];
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] adv;

    function automatic logic [14:0] div100_byte(input logic [6:0] rem, input logic [7:0] bits);
        logic [7:0] w;
        logic [6:0] r;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            w = {r, bits[i]};
            if (w >= D100)
            begin
                q[i] = 1'b1;
                w = w - D100;
            end
            r = w[6:0];
        end
        return {r, q};
    endfunction

    function automatic logic [27:0] div1m_byte(input logic [19:0] rem, input logic [7:0] bits);
        logic [20:0] w;
        logic [19:0] r;
        logic [7:0]  q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            w = {r, bits[i]};
            if (w >= D1M)
            begin
                q[i] = 1'b1;
                w = w - D1M;
            end
            r = w[19:0];
        end
        return {r, q};
    endfunction

    always_comb
    begin
        logic [7:0]  byte_w;
        logic [14:0] res100;
        logic [27:0] res1m;
        src[0]             = '0;
        src[0].mode        = up_data.mode;
        src[0].time_ns     = up_data.time_ns;
        src[0].field_bytes = up_data.field_bytes;
        for (int i = 1; i < NSTAGE; i++)
        begin
            src[i] = st_reg[i-1];
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            byte_w           = src[i].time_ns[63 - 8*i -: 8];
            res100           = div100_byte(src[i].r100, byte_w);
            res1m            = div1m_byte(src[i].r_ms, byte_w);
            st_next[i]       = src[i];
            st_next[i].r100  = res100[14:8];
            st_next[i].q100  = {src[i].q100[49:0], res100[7:0]};
            st_next[i].r_ms  = res1m[27:8];
            st_next[i].q_ms  = {src[i].q_ms[39:0], res1m[7:0]};
        end
    end

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[NSTAGE-1] = !v_reg[NSTAGE-1] || dn_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign up_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign dn_valid            = v_reg[NSTAGE-1];
    assign dn_data.mode        = st_reg[NSTAGE-1].mode;
    assign dn_data.field_bytes = st_reg[NSTAGE-1].field_bytes;
    assign dn_data.q100        = st_reg[NSTAGE-1].q100;
    assign dn_data.q_ms        = st_reg[NSTAGE-1].q_ms;
    assign dn_data.r_ms        = st_reg[NSTAGE-1].r_ms;

    a_rem_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGE-1] |-> (st_reg[NSTAGE-1].r100 < D100) && (st_reg[NSTAGE-1].r_ms < D1M))
        else $error("divider remainder out of range");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGE-1] && !dn_ready |=> v_reg[NSTAGE-1] && $stable(st_reg[NSTAGE-1]))
        else $error("divider tail changed while stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> v_reg[0])
        else $error("accepted transaction missing from first stage");

endmodule

// File: design/uuid_timestamp_codec.sv
// UUID timestamp codec (v1/v6/v7 encode and decode), top level.
// Pipeline: eight divider stages, then stage 8, stage 9 and the stage 10 output register.
// Throughput: one transaction per cycle unless dout stalls; the eight-stage constant divider
// (eight quotient bits per stage) and the 1/1000 reciprocal multipliers set the depth.
// Stalls collapse bubbles stage by stage; dout data is registered, ready is combinational.
// Reset clears only the valid bits; the data registers are not reset.
module uuid_timestamp_codec (
    input  logic      clk,
    input  logic      rst_n,
    utc_in_if.sink    din,
    utc_out_if.source dout
);
    import utc_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [59:0] n;
        logic [9:0]  us;
        logic [47:0] q_ms;
        logic [59:0] d;
        logic        under;
        logic        ms_ovf;
        logic [57:0] ms_k;
    } s8_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [59:0] n;
        logic [47:0] q_ms;
        logic [11:0] frac;
        logic        under;
        logic        d_ovf;
        logic [63:0] dec_g;
        logic        ms_ovf;
        logic [63:0] dec_ms;
    } s9_t;

    div_in_t  div_in;
    div_out_t div_out;
    logic     div_valid;
    logic     div_ready;

    s8_t  s8_reg, s8_next;
    s9_t  s9_reg, s9_next;
    logic v8_reg, v9_reg, v10_reg;
    logic adv8, adv9, adv10;

    logic [63:0] packed_reg, packed_next;
    logic [63:0] decoded_reg, decoded_next;
    logic        err_reg, err_next;

    assign div_in.mode        = din.mode;
    assign div_in.time_ns     = din.time_ns;
    assign div_in.field_bytes = din.field_bytes;

    utc_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (din.valid),
        .up_ready (din.ready),
        .up_data  (div_in),
        .dn_valid (div_valid),
        .dn_ready (div_ready),
        .dn_data  (div_out)
    );

    assign adv10     = !v10_reg || dout.ready;
    assign adv9      = !v9_reg || adv10;
    assign adv8      = !v8_reg || adv9;
    assign div_ready = adv8;

    // stage 8: Gregorian add, microsecond extract, decode field gather
    always_comb
    begin
        logic [59:0] t60;
        logic [47:0] ms;
        logic [40:0] prod_us;
        if (div_out.mode == MODE_DEC_V1)
        begin
            t60 = {div_out.field_bytes[11:0], div_out.field_bytes[31:16],
                   div_out.field_bytes[63:32]};
        end
        else
        begin
            t60 = {div_out.field_bytes[63:16], div_out.field_bytes[11:0]};
        end
        ms      = div_out.field_bytes[63:16];
        prod_us = 41'(div_out.r_ms) * 41'(RECIP_1000);

        s8_next.mode   = div_out.mode;
        s8_next.n      = 60'(div_out.q100) + GREG_OFFSET[59:0];
        s8_next.us     = prod_us[39:30];
        s8_next.q_ms   = div_out.q_ms;
        s8_next.under  = t60 < GREG_OFFSET[59:0];
        s8_next.d      = t60 - GREG_OFFSET[59:0];
        s8_next.ms_ovf = ms > MS_LIMIT;
        // x * 1000 = x * 1024 - x * 16 - x * 8
        s8_next.ms_k   = {ms, 10'b0} - 58'({ms, 4'b0}) - 58'({ms, 3'b0});
    end

    // stage 9: v7 fraction, scale decoded counts back to ns
    always_comb
    begin
        logic [42:0] prod_fr;
        prod_fr = 43'({s8_reg.us, 12'b0}) * 43'(RECIP_1000);

        s9_next.mode   = s8_reg.mode;
        s9_next.n      = s8_reg.n;
        s9_next.q_ms   = s8_reg.q_ms;
        s9_next.frac   = prod_fr[41:30];
        s9_next.under  = s8_reg.under;
        s9_next.d_ovf  = s8_reg.d > GREG_LIMIT;
        s9_next.dec_g  = 64'({s8_reg.d, 6'b0}) + 64'({s8_reg.d, 5'b0})
                       + 64'({s8_reg.d, 2'b0});
        s9_next.ms_ovf = s8_reg.ms_ovf;
        s9_next.dec_ms = 64'({s8_reg.ms_k, 10'b0}) - 64'({s8_reg.ms_k, 4'b0})
                       - 64'({s8_reg.ms_k, 3'b0});
    end

    // stage 10: layout select into the output register
    always_comb
    begin
        packed_next  = '0;
        decoded_next = '0;
        err_next     = 1'b0;
        case (s9_reg.mode)
            MODE_ENC_V1:
            begin
                packed_next = {s9_reg.n[31:0], s9_reg.n[47:32], VER_V1, s9_reg.n[59:48]};
            end
            MODE_ENC_V6:
            begin
                packed_next = {s9_reg.n[59:12], VER_V6, s9_reg.n[11:0]};
            end
            MODE_ENC_V7:
            begin
                packed_next = {s9_reg.q_ms, VER_V7, s9_reg.frac};
            end
            MODE_DEC_V1, MODE_DEC_V6:
            begin
                err_next     = s9_reg.under || s9_reg.d_ovf;
                decoded_next = err_next ? 64'd0 : s9_reg.dec_g;
            end
            MODE_DEC_V7:
            begin
                err_next     = s9_reg.ms_ovf;
                decoded_next = err_next ? 64'd0 : s9_reg.dec_ms;
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            if (adv8)
            begin
                v8_reg <= div_valid;
            end
            if (adv9)
            begin
                v9_reg <= v8_reg;
            end
            if (adv10)
            begin
                v10_reg <= v9_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv8)
        begin
            s8_reg <= s8_next;
        end
        if (adv9)
        begin
            s9_reg <= s9_next;
        end
        if (adv10)
        begin
            packed_reg  <= packed_next;
            decoded_reg <= decoded_next;
            err_reg     <= err_next;
        end
    end

    assign dout.valid        = v10_reg;
    assign dout.packed_bytes = packed_reg;
    assign dout.decoded_ns   = decoded_reg;
    assign dout.out_of_range = err_reg;

    a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.out_of_range |-> dout.decoded_ns == 64'd0
                                            && dout.packed_bytes == 64'd0)
        else $error("error result carries nonzero data");

    a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.packed_bytes != 64'd0 |-> !dout.out_of_range
                                                     && dout.decoded_ns == 64'd0)
        else $error("encode result mixed with decode fields");

    a_enc_version: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.packed_bytes != 64'd0 |-> dout.packed_bytes[15:12] == VER_V1
            || dout.packed_bytes[15:12] == VER_V6 || dout.packed_bytes[15:12] == VER_V7)
        else $error("encode result without a version nibble");

    a_s9_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg && !adv9 |=> v9_reg && $stable(s9_reg))
        else $error("stage 9 changed while stalled");

endmodule

// File: dv/tb_uuid_timestamp_codec.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UUID timestamp codec: directed corners, then random traffic.
module tb_uuid_timestamp_codec;
    import utc_pkg::*;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    // largest tick span and millisecond count that still fit 64 bits of ns
    localparam logic [63:0] TICK_MAX = ALL_ONES / 64'd100;
    localparam logic [63:0] MSEC_MAX = ALL_ONES / 64'd1000000;

    localparam logic [2:0] MODE_BAD_LO = 3'd6;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;

    localparam int RANDOM_ITEMS    = 750;
    localparam int QUIET_ITEMS     = 100;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [63:0] CORNER_TIMES [3] = '{64'd0, 64'd999999, ALL_ONES};
    localparam logic [63:0] CORNER_TICKS [6] = '{
        64'd0,
        GREG_OFFSET - 64'd1,
        GREG_OFFSET,
        GREG_OFFSET + TICK_MAX,
        GREG_OFFSET + TICK_MAX + 64'd1,
        64'h0FFF_FFFF_FFFF_FFFF
    };
    localparam logic [63:0] CORNER_MSEC [4] = '{
        64'd0, MSEC_MAX, MSEC_MAX + 64'd1, 64'h0000_FFFF_FFFF_FFFF
    };

    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [63:0] decoded_ns;
        logic        out_of_range;
    } codec_result_t;

    class ts_scoreboard;
        codec_result_t pending_results[$];
        int            fail_count;

        function new();
            fail_count = 0;
        endfunction

        function codec_result_t ticks_to_ns(logic [59:0] ticks);
            codec_result_t r;
            logic [63:0]   span;
            r    = '0;
            span = {4'b0, ticks} - GREG_OFFSET;
            if ({4'b0, ticks} < GREG_OFFSET || span > TICK_MAX)
                r.out_of_range = 1'b1;
            else
                r.decoded_ns = span * 64'd100;
            return r;
        endfunction

        function codec_result_t convert_timestamp(logic [2:0] mode, logic [63:0] t,
                                                  logic [63:0] b);
            codec_result_t r;
            logic [63:0]   ticks;
            logic [63:0]   t_msec;
            logic [63:0]   usec;
            logic [63:0]   frac;
            logic [63:0]   b_msec;
            r      = '0;
            ticks  = t / 64'd100 + GREG_OFFSET;
            t_msec = t / 64'd1000000;
            usec   = (t % 64'd1000000) / 64'd1000;
            frac   = (usec << 12) / 64'd1000;
            b_msec = {16'b0, b[63:16]};
            case (mode)
                MODE_ENC_V1: r.packed_bytes = {ticks[31:0], ticks[47:32], VER_V1, ticks[59:48]};
                MODE_ENC_V6: r.packed_bytes = {ticks[59:12], VER_V6, ticks[11:0]};
                MODE_ENC_V7: r.packed_bytes = {t_msec[47:0], VER_V7, frac[11:0]};
                MODE_DEC_V1: r = ticks_to_ns({b[11:0], b[31:16], b[63:32]});
                MODE_DEC_V6: r = ticks_to_ns({b[63:16], b[11:0]});
                MODE_DEC_V7:
                begin
                    if (b_msec > MSEC_MAX)
                        r.out_of_range = 1'b1;
                    else
                        r.decoded_ns = b_msec * 64'd1000000;
                end
                default: r.out_of_range = 1'b1;
            endcase
            return r;
        endfunction

        function void note_input(logic [2:0] mode, logic [63:0] t, logic [63:0] b);
            pending_results.push_back(convert_timestamp(mode, t, b));
        endfunction

        function void check_result(logic [63:0] packed_bytes, logic [63:0] decoded_ns,
                                   logic out_of_range);
            codec_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: packed_bytes=%h decoded_ns=%h out_of_range=%b",
                       packed_bytes, decoded_ns, out_of_range);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (packed_bytes !== want.packed_bytes)
            begin
                $error("packed_bytes: expected %h, actual %h", want.packed_bytes, packed_bytes);
                fail_count++;
            end
            if (decoded_ns !== want.decoded_ns)
            begin
                $error("decoded_ns: expected %h, actual %h", want.decoded_ns, decoded_ns);
                fail_count++;
            end
            if (out_of_range !== want.out_of_range)
            begin
                $error("out_of_range: expected %b, actual %b", want.out_of_range, out_of_range);
                fail_count++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet_tail = 1'b0;
    int   items_sent = 0;

    ts_scoreboard sb = new();

    utc_in_if  in_ch();
    utc_out_if out_ch();

    uuid_timestamp_codec u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // lay a 60-bit tick count out as v1 (mixed-endian) or v6 (big-endian) bytes
    function automatic logic [63:0] pack_ticks(logic [2:0] mode, logic [63:0] ticks,
                                               logic [3:0] nib);
        if (mode == MODE_DEC_V1)
            return {ticks[31:0], ticks[47:32], nib, ticks[59:48]};
        return {ticks[59:12], nib, ticks[11:0]};
    endfunction

    function automatic logic [63:0] pick_ticks();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = GREG_OFFSET + rand64() % (TICK_MAX + 64'd1);
            6:       v = GREG_OFFSET + TICK_MAX - 64'd3 + 64'($urandom_range(0, 6));
            7:       v = GREG_OFFSET - 64'd3 + 64'($urandom_range(0, 6));
            8:       v = rand64() % GREG_OFFSET;
            default: v = rand64() & 64'h0FFF_FFFF_FFFF_FFFF;
        endcase
        return v;
    endfunction

    function automatic logic [47:0] pick_msec();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0:       v = MSEC_MAX - 64'd2 + 64'($urandom_range(0, 4));
            1:       v = 64'($urandom_range(0, 100000));
            default: v = rand64();
        endcase
        return v[47:0];
    endfunction

    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return rand64() % 64'd1000000000;
            1:       return ALL_ONES - 64'($urandom_range(0, 2000000));
            default: return rand64();
        endcase
    endfunction

    // drive at the falling edge, hold until accepted, then maybe idle a burst
    task automatic send_item(input logic [2:0] mode, input logic [63:0] t, input logic [63:0] b);
        in_ch.valid       = 1'b1;
        in_ch.mode        = mode;
        in_ch.time_ns     = t;
        in_ch.field_bytes = b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(mode, t, b);
        items_sent++;
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [2:0]  mode;
        logic [63:0] t;
        logic [63:0] b;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_ENC_V1;
        in_ch.time_ns     = '0;
        in_ch.field_bytes = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int m = MODE_ENC_V1; m <= MODE_ENC_V7; m++)
            foreach (CORNER_TIMES[i])
                send_item(3'(m), CORNER_TIMES[i], rand64());
        foreach (CORNER_TICKS[i])
        begin
            send_item(MODE_DEC_V1, rand64(),
                      pack_ticks(MODE_DEC_V1, CORNER_TICKS[i], 4'($urandom)));
            send_item(MODE_DEC_V6, rand64(),
                      pack_ticks(MODE_DEC_V6, CORNER_TICKS[i], 4'($urandom)));
        end
        foreach (CORNER_MSEC[i])
            send_item(MODE_DEC_V7, rand64(), {CORNER_MSEC[i][47:0], 16'($urandom)});
        send_item(MODE_BAD_LO, rand64(), rand64());
        send_item(MODE_BAD_HI, rand64(), rand64());

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            if ($urandom_range(0, 19) == 0)
                mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
            else
                mode = 3'($urandom_range(MODE_ENC_V1, MODE_DEC_V7));
            t = pick_time();
            b = rand64();
            // mostly well-formed fields, some raw noise
            if ((mode == MODE_DEC_V1 || mode == MODE_DEC_V6) && $urandom_range(0, 7) != 0)
                b = pack_ticks(mode, pick_ticks(), 4'($urandom));
            else if (mode == MODE_DEC_V7 && $urandom_range(0, 7) != 0)
                b = {pick_msec(), b[15:0]};
            send_item(mode, t, b);
        end
        in_ch.valid = 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
            $display("[uuid_timestamp_codec] OK");
        else
            $display("[uuid_timestamp_codec] ERROR");
        $finish;
    end

    // result side: random stall bursts, one long hold-off to back up the pipeline
    initial
    begin
        bit held_off;
        held_off     = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && !quiet_tail && items_sent >= HOLD_OFF_AT)
            begin
                held_off     = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.packed_bytes, out_ch.decoded_ns, out_ch.out_of_range);
    end

    // watchdog: too many cycles with no transaction on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[uuid_timestamp_codec] ERROR");
        $finish;
    end

endmodule
